/* src/erwa_pkg.sv */
// Shared types, codes and constants for the event ring write accounting block.
// No dependencies; the design files refer to it by scoped names, the test files import it.
package erwa_pkg;

    // Ring and sampler dimensions
    localparam int unsigned RING_WORDS   = 65536;
    localparam int unsigned MAX_SAMPLERS = 8;

    // Field widths
    localparam int unsigned OFF_W      = 16;
    localparam int unsigned SIZE_W     = 17;
    localparam int unsigned NSAMP_W    = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned S_TDATA_W  = 72;
    localparam int unsigned S_TUSER_W  = 2;
    localparam int unsigned M_TDATA_W  = 96;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLERS  = 2'd1;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_WRITE    = 2'd0,
        REQ_RESYNC   = 2'd1,
        REQ_SNAPSHOT = 2'd2,
        REQ_NONE     = 2'd3
    } req_type_t;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_LOCKED = 2'd1,
        STS_FULL   = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_OUT  = 3'b100
    } fsm_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

    // One request as it arrives
    typedef struct packed {
        logic [1:0]       req_type;
        logic             write_allowed;
        logic [OFF_W-1:0] read_offset;
        logic             full_mark_in;
        logic [OFF_W-1:0] event_words;
        logic [OFF_W-1:0] field_offset;
        logic [OFF_W-1:0] field_words;
    } req_t;

    // One result
    typedef struct packed {
        logic [1:0]              status;
        logic [OFF_W-1:0]        start_offset;
        logic [OFF_W-1:0]        write_offset;
        logic                    full_mark_out;
        logic [MAX_SAMPLERS-1:0] samplers_empty;
        logic [OFF_W-1:0]        field_start;
        logic [OFF_W-1:0]        field_first_len;
        logic                    field_split;
        logic [OFF_W-1:0]        saved_offset;
    } res_t;

endpackage

/* src/erwa_ctrl.sv */
// Controller for the event ring write accounting block: request sequencing.
// Depends on erwa_pkg; drives the datapath through erwa_pkg::dp_cmd_t.
module erwa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output erwa_pkg::dp_cmd_t cmd
);

    erwa_pkg::fsm_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= erwa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands; a new request may enter as the result leaves
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            erwa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = erwa_pkg::ST_EXEC;
                end
            end
            erwa_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = erwa_pkg::ST_OUT;
            end
            erwa_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                s_tready = m_tready;
                if (m_tready) begin
                    if (s_tvalid) begin
                        cmd.load   = 1'b1;
                        state_next = erwa_pkg::ST_EXEC;
                    end else begin
                        state_next = erwa_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = erwa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/erwa_datapath.sv */
// Datapath for the event ring write accounting block: offsets, samplers,
// fit checks and the result register. Depends on erwa_pkg.
module erwa_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  erwa_pkg::dp_cmd_t                   cmd,
    input  erwa_pkg::req_t                      req,
    input  logic                                cfg_we,
    input  logic [erwa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [erwa_pkg::CFG_DATA_W-1:0]     cfg_data,
    output erwa_pkg::res_t                      res
);

    localparam int unsigned OW = erwa_pkg::OFF_W;
    localparam int unsigned SW = erwa_pkg::SIZE_W;
    localparam int unsigned NS = erwa_pkg::MAX_SAMPLERS;
    localparam int unsigned NW = erwa_pkg::NSAMP_W;

    // Configuration, stored already clamped
    logic [SW-1:0] size_reg;
    logic [NW-1:0] nsamp_reg;

    // Block state
    logic [OW-1:0] wr_reg, wr_next;
    logic [OW-1:0] saved_reg, saved_next;
    logic [OW-1:0] samp_reg [NS];
    logic [OW-1:0] samp_next [NS];
    logic [NS-1:0] flags_reg, flags_next;

    // Latched request, with the two offset sums taken at load
    erwa_pkg::req_type_t req_l_reg;
    logic                allowed_l_reg;
    logic [OW-1:0]       rd_l_reg;
    logic                mark_l_reg;
    logic [SW-1:0]       end_l_reg;
    logic [SW-1:0]       fpos_l_reg;
    logic [OW-1:0]       fw_l_reg;

    erwa_pkg::res_t res_reg, res_next;

    // Working signals of the write check
    logic [NS-1:0] active;
    logic          wr_ge_rd, end_ge_size, fits_wrap, ok, wrapped, mark_w;
    logic [SW-1:0] end_over, end_fin;
    logic          fpos_ge_size, fpos_fits;
    logic [SW-1:0] fpos_over, first_len;
    logic [SW:0]   fpos_fw;
    logic [NS-1:0] push;

    // Configuration writes with range clamps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= SW'(erwa_pkg::RING_WORDS);
            nsamp_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == erwa_pkg::CFG_RING_SIZE) begin
                if (cfg_data == '0) begin
                    size_reg <= SW'(1);
                end else if (cfg_data > SW'(erwa_pkg::RING_WORDS)) begin
                    size_reg <= SW'(erwa_pkg::RING_WORDS);
                end else begin
                    size_reg <= cfg_data[SW-1:0];
                end
            end else if (cfg_index == erwa_pkg::CFG_SAMPLERS) begin
                if (cfg_data[NW-1:0] > NW'(NS)) begin
                    nsamp_reg <= NW'(NS);
                end else begin
                    nsamp_reg <= cfg_data[NW-1:0];
                end
            end
        end
    end

    // Request latch
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_l_reg     <= erwa_pkg::req_type_t'(req.req_type);
            allowed_l_reg <= req.write_allowed;
            rd_l_reg      <= req.read_offset;
            mark_l_reg    <= req.full_mark_in;
            end_l_reg     <= {1'b0, wr_reg} + {1'b0, req.event_words};
            fpos_l_reg    <= {1'b0, wr_reg} + {1'b0, req.field_offset};
            fw_l_reg      <= req.field_words;
        end
    end

    // Active sampler mask
    always_comb begin
        for (int i = 0; i < NS; i++) begin
            active[i] = (NW'(i) < nsamp_reg);
        end
    end

    // Fit check and sub-field placement
    always_comb begin
        wr_ge_rd     = (wr_reg >= rd_l_reg);
        end_ge_size  = (end_l_reg >= size_reg);
        end_over     = end_l_reg - size_reg;
        fits_wrap    = (end_over <= {1'b0, rd_l_reg});
        ok           = 1'b0;
        wrapped      = 1'b0;
        mark_w       = 1'b0;
        if (wr_ge_rd) begin
            if (!end_ge_size) begin
                ok = 1'b1;
            end else if (fits_wrap) begin
                ok      = 1'b1;
                wrapped = 1'b1;
                mark_w  = (end_over == {1'b0, rd_l_reg});
            end
        end else if (end_l_reg <= {1'b0, rd_l_reg}) begin
            ok     = 1'b1;
            mark_w = (end_l_reg == {1'b0, rd_l_reg});
        end
        end_fin      = wrapped ? end_over : end_l_reg;
        fpos_ge_size = (fpos_l_reg >= size_reg);
        fpos_over    = fpos_l_reg - size_reg;
        fpos_fw      = {1'b0, fpos_l_reg} + {2'b00, fw_l_reg};
        fpos_fits    = (fpos_fw < {1'b0, size_reg});
        first_len    = size_reg - fpos_l_reg;
    end

    // Overrun test per sampler, side by side
    always_comb begin
        for (int i = 0; i < NS; i++) begin
            if (wrapped) begin
                push[i] = (wr_reg < samp_reg[i]) ||
                          ((wr_reg > samp_reg[i]) && (end_fin > {1'b0, samp_reg[i]}));
            end else begin
                push[i] = (end_fin > {1'b0, samp_reg[i]}) && (wr_reg < samp_reg[i]);
            end
        end
    end

    // Request execution: next state and result
    always_comb begin
        wr_next    = wr_reg;
        saved_next = saved_reg;
        flags_next = flags_reg;
        for (int i = 0; i < NS; i++) begin
            samp_next[i] = samp_reg[i];
        end
        res_next.status          = erwa_pkg::STS_OK;
        res_next.start_offset    = wr_reg;
        res_next.full_mark_out   = mark_l_reg;
        res_next.samplers_empty  = '0;
        res_next.field_start     = '0;
        res_next.field_first_len = '0;
        res_next.field_split     = 1'b0;
        case (req_l_reg)
            erwa_pkg::REQ_RESYNC: begin
                for (int i = 0; i < NS; i++) begin
                    if (active[i]) begin
                        samp_next[i] = wr_reg;
                    end
                end
                res_next.samplers_empty = active;
                flags_next              = flags_reg | active;
            end
            erwa_pkg::REQ_SNAPSHOT: begin
                saved_next = wr_reg;
            end
            erwa_pkg::REQ_WRITE: begin
                if (!allowed_l_reg) begin
                    res_next.status = erwa_pkg::STS_LOCKED;
                end else if ((wr_reg == rd_l_reg) && mark_l_reg) begin
                    res_next.status        = erwa_pkg::STS_FULL;
                    res_next.full_mark_out = 1'b1;
                end else if (!ok) begin
                    res_next.status        = erwa_pkg::STS_FULL;
                    res_next.full_mark_out = 1'b1;
                end else begin
                    res_next.full_mark_out = mark_w;
                    // sub-field placement
                    if (!wrapped) begin
                        res_next.field_start     = fpos_l_reg[OW-1:0];
                        res_next.field_first_len = fw_l_reg;
                    end else if (fpos_ge_size) begin
                        res_next.field_start     = fpos_over[OW-1:0];
                        res_next.field_first_len = fw_l_reg;
                    end else if (fpos_fits) begin
                        res_next.field_start     = fpos_l_reg[OW-1:0];
                        res_next.field_first_len = fw_l_reg;
                    end else begin
                        res_next.field_start     = fpos_l_reg[OW-1:0];
                        res_next.field_first_len = first_len[OW-1:0];
                        res_next.field_split     = 1'b1;
                    end
                    // push overrun samplers to the new write offset
                    for (int i = 0; i < NS; i++) begin
                        if (active[i]) begin
                            if (push[i]) begin
                                samp_next[i] = end_fin[OW-1:0];
                                flags_next[i] = 1'b1;
                                res_next.samplers_empty[i] = 1'b1;
                            end else begin
                                flags_next[i] = 1'b0;
                            end
                        end
                    end
                    wr_next = end_fin[OW-1:0];
                end
            end
            default: begin
            end
        endcase
        res_next.write_offset = wr_next;
        res_next.saved_offset = saved_next;
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            saved_reg <= '0;
            flags_reg <= '1;
            for (int i = 0; i < NS; i++) begin
                samp_reg[i] <= '0;
            end
        end else if (cmd.exec) begin
            wr_reg    <= wr_next;
            saved_reg <= saved_next;
            flags_reg <= flags_next;
            for (int i = 0; i < NS; i++) begin
                samp_reg[i] <= samp_next[i];
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* src/event_ring_write_accounting.sv */
// Event ring write accounting: top level joining controller and datapath.
// Depends on erwa_pkg, erwa_ctrl and erwa_datapath.
//
// Use: each request on the s_ channel is a write-event, resync or snapshot
// descriptor (kind in s_tuser); exactly one result leaves on the m_ channel
// for each request, in order. Configuration (ring size, samplers in use)
// is written on the cfg_ channel, which is always ready; write it only while
// no request is in flight.
// Sequence: an accepted request is latched, then the fit, sampler and field
// checks are evaluated into the result register, which is then offered.
// The controller takes no new request while a result waits; the next request
// is taken in the same cycle that the current result is taken.
// Reset (aresetn low, synchronous): write and snapshot offsets and sampler
// pointers clear to zero, sampler empty flags set, ring size 65536, no
// samplers in use, no result pending.
// Stall: while m_tready is low the result is held and no new request is
// accepted.
module event_ring_write_accounting (
    input  logic                                aclk,
    input  logic                                aresetn,
    // fields from bit 0: write_allowed, read_offset, full_mark_in,
    // event_words, field_offset, field_words, zero pad
    input  logic [erwa_pkg::S_TDATA_W-1:0]      s_tdata,
    // fields from bit 0: req_type
    input  logic [erwa_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // fields from bit 0: status, start_offset, write_offset, full_mark_out,
    // samplers_empty, field_start, field_first_len, field_split,
    // saved_offset, zero pad
    output logic [erwa_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [erwa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [erwa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned RES_W = $bits(erwa_pkg::res_t);

    erwa_pkg::dp_cmd_t cmd;
    erwa_pkg::req_t    req;
    erwa_pkg::res_t    res;
    logic [RES_W-1:0]  res_bits;

    // Unpack the incoming request
    assign req.req_type        = s_tuser;
    assign req.write_allowed   = s_tdata[0];
    assign req.read_offset     = s_tdata[16:1];
    assign req.full_mark_in    = s_tdata[17];
    assign req.event_words     = s_tdata[33:18];
    assign req.field_offset    = s_tdata[49:34];
    assign req.field_words     = s_tdata[65:50];

    assign cfg_ready = 1'b1;

    erwa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    erwa_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    // Pack the result, first field lowest
    assign res_bits = {res.saved_offset, res.field_split, res.field_first_len,
                       res.field_start, res.samplers_empty, res.full_mark_out,
                       res.write_offset, res.start_offset, res.status};
    assign m_tdata  = {{(erwa_pkg::M_TDATA_W-RES_W){1'b0}}, res_bits};

endmodule

/* test/ring_account_checker.sv */
// Checker for the event ring write accounting block: watches the request, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on erwa_pkg for the request/result layouts, codes and ring dimensions.
module ring_account_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    // fields from bit 0: write_allowed, read_offset, full_mark_in,
    // event_words, field_offset, field_words, zero pad
    input  logic [erwa_pkg::S_TDATA_W-1:0]    s_tdata,
    // fields from bit 0: req_type
    input  logic [erwa_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // fields from bit 0: status, start_offset, write_offset, full_mark_out,
    // samplers_empty, field_start, field_first_len, field_split,
    // saved_offset, zero pad
    input  logic [erwa_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [erwa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [erwa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                mismatch_count,
    output int                                outcomes_due
);
    import erwa_pkg::*;

    // Shadow of the block's registers and ring bookkeeping
    logic [SIZE_W-1:0]  ring_cfg;
    logic [NSAMP_W-1:0] samp_cfg;
    logic [OFF_W-1:0]   wr_off;
    logic [OFF_W-1:0]   saved_off;
    logic [OFF_W-1:0]   samp_off [MAX_SAMPLERS];

    res_t pending_outcomes [$];

    initial begin
        mismatch_count = 0;
        outcomes_due   = 0;
    end

    // Work out the result of one request and move the shadow state on
    function automatic res_t account_request(req_t rq);
        res_t        o;
        int unsigned size, nsamp, wr, rd, ev, fo, fw, fin, fpos, sm, i;
        logic        ok, wrapped, push;
        size  = (ring_cfg == 0) ? 1 : ((ring_cfg > RING_WORDS) ? RING_WORDS : ring_cfg);
        nsamp = (samp_cfg > MAX_SAMPLERS) ? MAX_SAMPLERS : samp_cfg;
        wr    = wr_off;
        rd    = rq.read_offset;
        ev    = rq.event_words;
        fo    = rq.field_offset;
        fw    = rq.field_words;
        o                = '0;
        o.status         = STS_OK;
        o.start_offset   = wr_off;
        o.full_mark_out  = rq.full_mark_in;

        case (req_type_t'(rq.req_type))
            REQ_RESYNC: begin
                for (i = 0; i < nsamp; i++) begin
                    samp_off[i]         = wr_off;
                    o.samplers_empty[i] = 1'b1;
                end
            end
            REQ_SNAPSHOT: begin
                saved_off = wr_off;
            end
            REQ_WRITE: begin
                if (!rq.write_allowed) begin
                    o.status = STS_LOCKED;
                end else if (wr == rd && rq.full_mark_in) begin
                    o.status        = STS_FULL;
                    o.full_mark_out = 1'b1;
                end else begin
                    fin     = wr + ev;
                    ok      = 1'b0;
                    wrapped = 1'b0;
                    // does the event fit before the end, or wrapped up to the reader
                    if (wr >= rd) begin
                        if (fin < size) begin
                            ok              = 1'b1;
                            o.full_mark_out = 1'b0;
                        end else if (fin - size <= rd) begin
                            ok              = 1'b1;
                            wrapped         = 1'b1;
                            fin             = fin - size;
                            o.full_mark_out = (fin == rd);
                        end
                    end else if (fin <= rd) begin
                        ok              = 1'b1;
                        o.full_mark_out = (fin == rd);
                    end

                    if (!ok) begin
                        o.status        = STS_FULL;
                        o.full_mark_out = 1'b1;
                    end else begin
                        // place the sub-field; only a wrapping write can split it
                        fpos = wr + fo;
                        if (wrapped && fpos >= size) begin
                            o.field_start     = 16'(fpos - size);
                            o.field_first_len = 16'(fw);
                        end else if (wrapped && fpos + fw >= size) begin
                            o.field_start     = 16'(fpos);
                            o.field_first_len = 16'(size - fpos);
                            o.field_split     = 1'b1;
                        end else begin
                            o.field_start     = 16'(fpos);
                            o.field_first_len = 16'(fw);
                        end
                        // samplers overrun by the event are pushed to the new offset
                        for (i = 0; i < nsamp; i++) begin
                            sm = samp_off[i];
                            if (wrapped)
                                push = (wr < sm) || (wr > sm && fin > sm);
                            else
                                push = (fin > sm) && (wr < sm);
                            if (push) begin
                                samp_off[i]         = 16'(fin);
                                o.samplers_empty[i] = 1'b1;
                            end
                        end
                        wr_off = 16'(fin);
                    end
                end
            end
            default: ;
        endcase

        o.write_offset = wr_off;
        o.saved_offset = saved_off;
        return o;
    endfunction

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    // Channel monitor: results are checked before new requests are queued
    always @(posedge aclk) begin : monitor
        req_t rq;
        res_t want, got;
        if (!aresetn) begin
            ring_cfg  = RING_WORDS;
            samp_cfg  = '0;
            wr_off    = '0;
            saved_off = '0;
            for (int i = 0; i < MAX_SAMPLERS; i++)
                samp_off[i] = '0;
            pending_outcomes.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RING_SIZE: ring_cfg = cfg_data[SIZE_W-1:0];
                    CFG_SAMPLERS:  samp_cfg = cfg_data[NSAMP_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got.status          = m_tdata[1:0];
                got.start_offset    = m_tdata[17:2];
                got.write_offset    = m_tdata[33:18];
                got.full_mark_out   = m_tdata[34];
                got.samplers_empty  = m_tdata[42:35];
                got.field_start     = m_tdata[58:43];
                got.field_first_len = m_tdata[74:59];
                got.field_split     = m_tdata[75];
                got.saved_offset    = m_tdata[91:76];
                if (pending_outcomes.size() == 0) begin
                    $error("result with no request outstanding: tdata 0x%0h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("start_offset", want.start_offset, got.start_offset);
                    compare_field("write_offset", want.write_offset, got.write_offset);
                    compare_field("full_mark_out", want.full_mark_out, got.full_mark_out);
                    compare_field("samplers_empty", want.samplers_empty,
                                  got.samplers_empty);
                    compare_field("field_start", want.field_start, got.field_start);
                    compare_field("field_first_len", want.field_first_len,
                                  got.field_first_len);
                    compare_field("field_split", want.field_split, got.field_split);
                    compare_field("saved_offset", want.saved_offset, got.saved_offset);
                end
            end

            if (s_tvalid && s_tready) begin
                rq.req_type      = s_tuser;
                rq.write_allowed = s_tdata[0];
                rq.read_offset   = s_tdata[16:1];
                rq.full_mark_in  = s_tdata[17];
                rq.event_words   = s_tdata[33:18];
                rq.field_offset  = s_tdata[49:34];
                rq.field_words   = s_tdata[65:50];
                pending_outcomes.push_back(account_request(rq));
            end
        end
        outcomes_due <= pending_outcomes.size();
    end

endmodule

/* test/event_ring_write_accounting_test.sv */
// Testbench top for the event ring write accounting block: clock, reset, request and
// configuration stimulus, result back-pressure, watchdog and final verdict.
// Depends on erwa_pkg, event_ring_write_accounting and ring_account_checker.
module event_ring_write_accounting_test;
    import erwa_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          mismatch_count;
    int          outcomes_due;
    int          quiet_cycles = 0;
    int          burst_left   = 0;
    int unsigned ring_words   = RING_WORDS;
    logic [15:0] seen_wr      = '0;
    logic        seen_mark    = 1'b0;

    event_ring_write_accounting dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ring_account_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outcomes_due   (outcomes_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Last write offset and full mark handed back, to steer the reader offset
    always @(posedge aclk) begin
        if (!aresetn) begin
            seen_wr   <= '0;
            seen_mark <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            seen_wr   <= m_tdata[33:18];
            seen_mark <= m_tdata[34];
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: one long hold-off first so the block backs up, then mixed stalls
    initial begin
        int mode;
        int span;
        wait (aresetn);
        repeat (100) @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 9);
            span = $urandom_range(1, 40);
            case (mode)
                0, 1, 2, 3: begin
                    m_tready <= 1'b1;
                    repeat (span) @(posedge aclk);
                end
                4, 5, 6: begin
                    repeat (span) begin
                        m_tready <= 1'($urandom_range(0, 1));
                        @(posedge aclk);
                    end
                end
                7, 8: begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end
                default: begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(60, 120)) @(posedge aclk);
                end
            endcase
        end
    end

    function automatic logic [S_TDATA_W-1:0] request_word(
        input logic allowed, input logic [15:0] rd, input logic mark,
        input logic [15:0] ev, input logic [15:0] fo, input logic [15:0] fw);
        return {6'd0, fw, fo, ev, mark, rd, allowed};
    endfunction

    // Offer one request and hold it until taken; bursts end in a random gap
    task automatic send_req(input req_type_t kind, input logic [S_TDATA_W-1:0] data);
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_index <= idx;
        cfg_data  <= 17'(value);
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Drain: stop offering and wait for every outstanding result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outcomes_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly well-formed writes whose reader sits near the writer, with noise
    task automatic send_random(input int count);
        req_type_t   kind;
        logic        allowed, mark;
        logic [15:0] rd, ev, fo, fw;
        int unsigned pick, free_words;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            kind = (pick < 80) ? REQ_WRITE : (pick < 88) ? REQ_RESYNC :
                   (pick < 96) ? REQ_SNAPSHOT : REQ_NONE;
            allowed = ($urandom_range(0, 11) != 0);

            case ($urandom_range(0, 9))
                0, 1, 2: rd = seen_wr;
                3, 4, 5: rd = 16'((seen_wr + $urandom_range(0, ring_words - 1)) % ring_words);
                6:       rd = 16'((seen_wr + ring_words * 4 - $urandom_range(1, 4))
                              % ring_words);
                7, 8:    rd = 16'((seen_wr + $urandom_range(1, 4)) % ring_words);
                default: rd = 16'($urandom);
            endcase
            mark = (rd == seen_wr && $urandom_range(0, 2) != 0) ? seen_mark
                                                                : 1'($urandom_range(0, 1));

            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                ev = 16'($urandom_range(0, (ring_words + 3) / 4));
            end else if (pick < 70) begin
                ev = 16'($urandom_range(0, ring_words));
            end else if (pick < 85) begin
                // exactly the free space, or one word over
                free_words = (rd + ring_words - seen_wr % ring_words) % ring_words;
                if (free_words == 0)
                    free_words = ring_words;
                ev = 16'(free_words + $urandom_range(0, 1));
            end else if (pick < 95) begin
                ev = 16'($urandom_range(0, 3));
            end else begin
                ev = 16'($urandom);
            end

            if ($urandom_range(0, 3) != 0) begin
                fo = 16'($urandom_range(0, ev));
                fw = 16'($urandom_range(0, ev - fo));
            end else begin
                fo = 16'($urandom);
                fw = 16'($urandom);
            end
            send_req(kind, request_word(allowed, rd, mark, ev, fo, fw));
        end
    endtask

    // Stimulus and verdict
    initial begin
        int unsigned sz, ns;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: small ring, all samplers active
        write_reg(CFG_RING_SIZE, 16);
        write_reg(CFG_SAMPLERS, 8);
        cfg_valid <= 1'b0;
        send_req(REQ_RESYNC,   request_word(1, 0, 0, 0, 0, 0));
        send_req(REQ_WRITE,    request_word(0, 0, 0, 4, 0, 1));      // locked
        send_req(REQ_WRITE,    request_word(1, 0, 1, 4, 0, 1));      // equal offsets, mark set
        send_req(REQ_WRITE,    request_word(1, 0, 0, 5, 1, 3));      // plain fit
        send_req(REQ_SNAPSHOT, request_word(1, 0, 0, 0, 0, 0));
        send_req(REQ_WRITE,    request_word(1, 3, 0, 14, 9, 4));     // wrap onto reader, split
        send_req(REQ_WRITE,    request_word(1, 3, 1, 2, 0, 0));
        send_req(REQ_WRITE,    request_word(1, 3, 0, 0, 0, 0));      // empty event
        send_req(REQ_WRITE,    request_word(1, 10, 0, 7, 2, 5));     // ends on the reader
        send_req(REQ_RESYNC,   request_word(1, 0, 0, 0, 0, 0));
        send_req(REQ_WRITE,    request_word(1, 9, 0, 20, 0, 0));     // does not fit
        send_req(REQ_WRITE,    request_word(1, 8, 0, 14, 7, 3));     // sub-field past the wrap
        send_req(REQ_WRITE,    request_word(1, 2, 0, 5, 16'hFFFF, 16'hFFFF));
        send_req(REQ_NONE,     request_word(1, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_req(REQ_WRITE,    request_word(1, 16'hFFFF, 0, 16'hFFFF, 0, 0));
        send_req(REQ_WRITE,    request_word(1, 0, 0, 3, 0, 0));      // wraps to offset zero
        send_req(REQ_SNAPSHOT, request_word(0, 0, 0, 0, 0, 0));
        send_req(REQ_WRITE,    request_word(1, 16'hFFFF, 0, 100, 0, 0)); // reader past ring end
        settle();

        // Directed: full-size ring, longest events
        write_reg(CFG_RING_SIZE, RING_WORDS);
        cfg_valid <= 1'b0;
        send_req(REQ_WRITE,  request_word(1, 100, 0, 16'hFFFF, 0, 16'hFFFF));
        send_req(REQ_WRITE,  request_word(1, 100, 0, 1, 0, 0));
        send_req(REQ_WRITE,  request_word(1, 100, 1, 0, 0, 0));
        send_req(REQ_RESYNC, request_word(1, 0, 0, 0, 0, 0));

        // Random phases over a spread of ring sizes and sampler counts
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0:       begin sz = 16;     ns = 8;  end
                1:       begin sz = 65536;  ns = 3;  end
                2:       begin sz = 1;      ns = 8;  end
                3:       begin sz = 0;      ns = 15; end
                4:       begin sz = 100000; ns = 9;  end
                5:       begin sz = 37;     ns = 5;  end
                6:       begin sz = 256;    ns = 0;  end
                default: begin sz = 131071; ns = 8;  end
            endcase
            write_reg(CFG_RING_SIZE, sz);
            write_reg(CFG_SAMPLERS, ns | (ph[0] << 16));
            cfg_valid <= 1'b0;
            ring_words = (sz == 0) ? 1 : ((sz > RING_WORDS) ? RING_WORDS : sz);
            send_random(86);
        end
        settle();

        if (mismatch_count == 0 && outcomes_due == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
src/erwa_pkg.sv
src/erwa_ctrl.sv
src/erwa_datapath.sv
src/event_ring_write_accounting.sv
test/ring_account_checker.sv
test/event_ring_write_accounting_test.sv
